// File: rtl/core/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared constants and types for the HSV color adjust pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 16;
  localparam int FIELD_BITS   = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int OFFSET_BITS  = 10;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_HUE_OFFSET,
    CFG_SAT_OFFSET,
    CFG_VAL_OFFSET
  } cfg_index_t;

endpackage

// File: rtl/core/hca_front.sv
// ----------------------------------------------------------------------------
// hca_front
// Input register, max/min/chroma and sextant numerator, divider operands.
// ----------------------------------------------------------------------------
module hca_front #(
  parameter int CB = hca_pkg::CHANNEL_BITS,
  parameter int HB = hca_pkg::HUE_BITS,
  parameter int NW = 32,
  parameter int DW = CB + 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [hca_pkg::FIELD_BITS-1:0]  in_red,
  input  logic [hca_pkg::FIELD_BITS-1:0]  in_green,
  input  logic [hca_pkg::FIELD_BITS-1:0]  in_blue,
  output logic                            out_valid,
  output logic [NW-1:0]                   hue_num,
  output logic [DW-1:0]                   hue_den,
  output logic [NW-1:0]                   sat_num,
  output logic [DW-1:0]                   sat_den,
  output logic [CB-1:0]                   max_ch,
  output logic                            gray
);

  logic [CB+7:0] red_w, green_w, blue_w;
  logic          v1_r, v2_r, v3_r;
  logic [CB-1:0] r1_r, g1_r, b1_r;
  logic [CB-1:0] mx_nxt, mn_nxt, c_nxt;
  logic [CB+2:0] n_nxt;
  logic signed [CB+3:0] n_s, c_s, r_s, g_s, b_s;
  logic [CB-1:0] mx2_r, c2_r;
  logic [CB+2:0] n2_r;
  logic [2*CB-1:0] cm;
  logic [NW-1:0] hue_num_r, sat_num_r;
  logic [DW-1:0] hue_den_r, sat_den_r;
  logic [CB-1:0] mx3_r;
  logic          gray_r;

  assign red_w   = {{CB{1'b0}}, in_red};
  assign green_w = {{CB{1'b0}}, in_green};
  assign blue_w  = {{CB{1'b0}}, in_blue};

  always_ff @(posedge clk) begin
    r1_r <= red_w[CB-1:0];
    g1_r <= green_w[CB-1:0];
    b1_r <= blue_w[CB-1:0];
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_comb begin
    mx_nxt = r1_r;
    mn_nxt = r1_r;
    if (g1_r > mx_nxt) mx_nxt = g1_r;
    if (b1_r > mx_nxt) mx_nxt = b1_r;
    if (g1_r < mn_nxt) mn_nxt = g1_r;
    if (b1_r < mn_nxt) mn_nxt = b1_r;
    c_nxt = mx_nxt - mn_nxt;
    c_s = $signed({4'b0, c_nxt});
    r_s = $signed({4'b0, r1_r});
    g_s = $signed({4'b0, g1_r});
    b_s = $signed({4'b0, b1_r});
    if (r1_r == mx_nxt) begin
      n_s = g_s - b_s;
      if (n_s < 0) n_s = n_s + (c_s <<< 2) + (c_s <<< 1);
    end else if (g1_r == mx_nxt) begin
      n_s = (c_s <<< 1) + b_s - r_s;
    end else begin
      n_s = (c_s <<< 2) + r_s - g_s;
    end
    n_nxt = n_s[CB+2:0];
  end

  always_ff @(posedge clk) begin
    mx2_r <= mx_nxt;
    c2_r  <= c_nxt;
    n2_r  <= n_nxt;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  assign cm = ({c2_r, {CB{1'b0}}}) - (2*CB)'(c2_r);

  always_ff @(posedge clk) begin
    hue_num_r <= NW'(n2_r) << HB;
    hue_den_r <= (DW'(c2_r) << 2) + (DW'(c2_r) << 1);
    sat_num_r <= NW'({cm, 8'b0});
    sat_den_r <= DW'(mx2_r);
    mx3_r     <= mx2_r;
    gray_r    <= (c2_r == '0);
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign hue_num   = hue_num_r;
  assign hue_den   = hue_den_r;
  assign sat_num   = sat_num_r;
  assign sat_den   = sat_den_r;
  assign max_ch    = mx3_r;
  assign gray      = gray_r;

endmodule

// File: rtl/core/hca_div.sv
// ----------------------------------------------------------------------------
// hca_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// ----------------------------------------------------------------------------
module hca_div #(
  parameter int NW = 32,
  parameter int DW = 11,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic [TW-1:0] tag_r [NW];
  logic          vld_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] nq_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [DW:0]   trial, diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_r[i]  <= {nq_in[NW-2:0], ge};
      den_r[i] <= den_in;
      tag_r[i] <= tag_in;
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quo       = nq_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule

// File: rtl/core/hca_back.sv
// ----------------------------------------------------------------------------
// hca_back
// Offset and clamp, sector split, channel products and scale back to RGB.
// ----------------------------------------------------------------------------
module hca_back #(
  parameter int CB = hca_pkg::CHANNEL_BITS,
  parameter int HB = hca_pkg::HUE_BITS,
  parameter int SW = CB + 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [HB-1:0]                      hue,
  input  logic [SW-1:0]                      sat,
  input  logic [CB-1:0]                      max_ch,
  input  logic                               gray,
  input  logic [hca_pkg::CFG_DATA_BITS-1:0]  hue_offset,
  input  logic signed [hca_pkg::OFFSET_BITS-1:0] sat_offset,
  input  logic signed [hca_pkg::OFFSET_BITS-1:0] val_offset,
  output logic                               out_valid,
  output logic [hca_pkg::FIELD_BITS-1:0]     out_red,
  output logic [hca_pkg::FIELD_BITS-1:0]     out_green,
  output logic [hca_pkg::FIELD_BITS-1:0]     out_blue
);

  localparam int M_I = (1 << CB) - 1;
  localparam logic [SW-1:0] U_W = SW'(256 * M_I);
  localparam int PW = SW + HB + 2;
  localparam int XW = 2 * CB;
  localparam logic [2*SW-1:0] RND_W = (2*SW)'(32768 * M_I);
  localparam logic [XW:0] M1_W = (XW+1)'(M_I);
  localparam logic [XW:0] M2_W = (XW+1)'(2 * M_I);
  localparam logic [PW-1:0] HALF_W = PW'(1) << (HB - 1);
  localparam logic [2:0] SEC_R = 3'd0;
  localparam logic [2:0] SEC_Y = 3'd1;
  localparam logic [2:0] SEC_G = 3'd2;
  localparam logic [2:0] SEC_C = 3'd3;
  localparam logic [2:0] SEC_B = 3'd4;

  // lane order: value, p, q, t
  localparam int LV = 0;
  localparam int LP = 1;
  localparam int LQ = 2;
  localparam int LT = 3;

  logic [6:0] vld_r;

  // stage 1: offsets and clamp
  logic [HB+15:0]    hoff_w;
  logic [HB-1:0]     h0, hv_nxt;
  logic [SW-1:0]     s0, v0, s1_nxt, v1_nxt;
  logic signed [SW+2:0] sat_e, val_e, satm, valm, ssum, vsum, u_s;
  logic [HB-1:0]     hv1_r;
  logic [SW-1:0]     s1_r, v1_r;

  always_comb begin
    hoff_w = {hue_offset, {HB{1'b0}}};
    h0     = gray ? '0 : hue;
    s0     = gray ? '0 : sat;
    v0     = {max_ch, 8'b0};
    hv_nxt = h0 + hoff_w[HB+15:16];
    sat_e  = (SW+3)'(sat_offset);
    val_e  = (SW+3)'(val_offset);
    satm   = (sat_e <<< CB) - sat_e;
    valm   = (val_e <<< CB) - val_e;
    u_s    = $signed({3'b0, U_W});
    ssum   = $signed({3'b0, s0}) + satm;
    vsum   = $signed({3'b0, v0}) + valm;
    if (ssum < 0) s1_nxt = '0;
    else if (ssum > u_s) s1_nxt = U_W;
    else s1_nxt = ssum[SW-1:0];
    if (vsum < 0) v1_nxt = '0;
    else if (vsum > u_s) v1_nxt = U_W;
    else v1_nxt = vsum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    hv1_r <= hv_nxt;
    s1_r  <= s1_nxt;
    v1_r  <= v1_nxt;
  end

  // stage 2: sector and fraction
  logic [HB+2:0] hv6;
  logic [2:0]    sec2_r;
  logic [HB-1:0] f2_r;
  logic [HB:0]   fc2_r;
  logic [SW-1:0] s2_r, v2_r;

  assign hv6 = ({3'b0, hv1_r} << 2) + ({3'b0, hv1_r} << 1);

  always_ff @(posedge clk) begin
    sec2_r <= hv6[HB+2:HB];
    f2_r   <= hv6[HB-1:0];
    fc2_r  <= {1'b1, {HB{1'b0}}} - {1'b0, hv6[HB-1:0]};
    s2_r   <= s1_r;
    v2_r   <= v1_r;
  end

  // stage 3: saturation times fraction
  logic [PW-1:0] pq3_r, pt3_r;
  logic [2:0]    sec3_r;
  logic [SW-1:0] s3_r, v3_r;

  always_ff @(posedge clk) begin
    pq3_r  <= PW'(s2_r) * PW'(f2_r);
    pt3_r  <= PW'(s2_r) * PW'(fc2_r);
    sec3_r <= sec2_r;
    s3_r   <= s2_r;
    v3_r   <= v2_r;
  end

  // stage 4: round and complement
  logic [PW-1:0] rq, rt;
  logic [SW+1:0] aq, at;
  logic [SW-1:0] k4_r [4];
  logic [2:0]    sec4_r;
  logic [SW-1:0] v4_r;

  always_comb begin
    rq = pq3_r + HALF_W;
    rt = pt3_r + HALF_W;
    aq = rq[PW-1:HB];
    at = rt[PW-1:HB];
  end

  always_ff @(posedge clk) begin
    k4_r[LV] <= U_W;
    k4_r[LP] <= U_W - s3_r;
    k4_r[LQ] <= (aq > {2'b0, U_W}) ? '0 : U_W - aq[SW-1:0];
    k4_r[LT] <= (at > {2'b0, U_W}) ? '0 : U_W - at[SW-1:0];
    sec4_r   <= sec3_r;
    v4_r     <= v3_r;
  end

  // stages 5..7: value times k, scale by 1/(65536*M) with rounding
  logic [2*SW-1:0] prod5_r [4];
  logic [XW-1:0]   x6_r [4];
  logic [CB:0]     q06_r [4];
  logic [CB-1:0]   ch [4];
  logic [2:0]      sec5_r, sec6_r;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [2*SW-1:0] psum;
    logic [XW-1:0]   x;
    logic [XW:0]     est, qm, rm;
    logic [CB:0]     q;

    always_comb begin
      psum = prod5_r[l] + RND_W;
      x    = psum[2*SW-1:16];
      est  = {1'b0, x} + (XW+1)'(x >> CB);
      qm   = {q06_r[l], {CB{1'b0}}} - (XW+1)'(q06_r[l]);
      rm   = {1'b0, x6_r[l]} - qm;
      if (rm >= M2_W) q = q06_r[l] + (CB+1)'(2);
      else if (rm >= M1_W) q = q06_r[l] + (CB+1)'(1);
      else q = q06_r[l];
      ch[l] = q[CB-1:0];
    end

    always_ff @(posedge clk) begin
      prod5_r[l] <= (2*SW)'(v4_r) * (2*SW)'(k4_r[l]);
      x6_r[l]    <= x;
      q06_r[l]   <= est[XW:CB];
    end
  end

  logic [CB-1:0] r_sel, g_sel, b_sel;
  logic [CB+7:0] r_w, g_w, b_w;
  logic [hca_pkg::FIELD_BITS-1:0] red_r, green_r, blue_r;

  always_comb begin
    case (sec6_r)
      SEC_R: begin
        r_sel = ch[LV]; g_sel = ch[LT]; b_sel = ch[LP];
      end
      SEC_Y: begin
        r_sel = ch[LQ]; g_sel = ch[LV]; b_sel = ch[LP];
      end
      SEC_G: begin
        r_sel = ch[LP]; g_sel = ch[LV]; b_sel = ch[LT];
      end
      SEC_C: begin
        r_sel = ch[LP]; g_sel = ch[LQ]; b_sel = ch[LV];
      end
      SEC_B: begin
        r_sel = ch[LT]; g_sel = ch[LP]; b_sel = ch[LV];
      end
      default: begin
        r_sel = ch[LV]; g_sel = ch[LP]; b_sel = ch[LQ];
      end
    endcase
    r_w = {8'b0, r_sel};
    g_w = {8'b0, g_sel};
    b_w = {8'b0, b_sel};
  end

  always_ff @(posedge clk) begin
    sec5_r  <= sec4_r;
    sec6_r  <= sec5_r;
    red_r   <= r_w[7:0];
    green_r <= g_w[7:0];
    blue_r  <= b_w[7:0];
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  assign out_valid = vld_r[6];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// File: rtl/core/hsv_color_adjust.sv
// ----------------------------------------------------------------------------
// hsv_color_adjust
// RGB to HSV, hue/saturation/value offsets, HSV back to RGB, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  ports                                      transfer
//  input    start, busy, in_red/green/blue             start && !busy
//  result   out_valid, out_red/green/blue              out_valid, one cycle
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
//  One pixel per clock. The front end feeds two restoring dividers (hue and
//  saturation) of NW quotient bits, NW being the larger of CB+3+HB and 2*CB+8
//  (27 at defaults); each retires one quotient bit per stage.
//  Synchronous reset clears the valid bits and the offset registers.
//  busy stays low; the pipeline never stalls.
// ----------------------------------------------------------------------------
module hsv_color_adjust #(
  parameter int CHANNEL_BITS = hca_pkg::CHANNEL_BITS,
  parameter int HUE_BITS     = hca_pkg::HUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [hca_pkg::FIELD_BITS-1:0]      in_red,
  input  logic [hca_pkg::FIELD_BITS-1:0]      in_green,
  input  logic [hca_pkg::FIELD_BITS-1:0]      in_blue,
  output logic                                out_valid,
  output logic [hca_pkg::FIELD_BITS-1:0]      out_red,
  output logic [hca_pkg::FIELD_BITS-1:0]      out_green,
  output logic [hca_pkg::FIELD_BITS-1:0]      out_blue,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hca_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hca_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB  = CHANNEL_BITS;
  localparam int HB  = HUE_BITS;
  localparam int NWH = CB + 3 + HB;
  localparam int NWS = 2 * CB + 8;
  localparam int NW  = (NWH > NWS) ? NWH : NWS;
  localparam int DW  = CB + 3;
  localparam int SW  = CB + 8;

  logic [hca_pkg::CFG_DATA_BITS-1:0]     hue_off_r;
  logic signed [hca_pkg::OFFSET_BITS-1:0] sat_off_r, val_off_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_off_r <= '0;
      sat_off_r <= '0;
      val_off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hca_pkg::CFG_HUE_OFFSET: hue_off_r <= cfg_data;
        hca_pkg::CFG_SAT_OFFSET: sat_off_r <= cfg_data[hca_pkg::OFFSET_BITS-1:0];
        hca_pkg::CFG_VAL_OFFSET: val_off_r <= cfg_data[hca_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic          f_valid, f_gray;
  logic [NW-1:0] f_hnum, f_snum;
  logic [DW-1:0] f_hden, f_sden;
  logic [CB-1:0] f_mx;

  hca_front #(.CB(CB), .HB(HB), .NW(NW), .DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .out_valid(f_valid),
    .hue_num  (f_hnum),
    .hue_den  (f_hden),
    .sat_num  (f_snum),
    .sat_den  (f_sden),
    .max_ch   (f_mx),
    .gray     (f_gray)
  );

  logic          hd_valid, sd_valid;
  logic [NW-1:0] hd_quo, sd_quo;
  logic [CB-1:0] hd_mx;
  logic          sd_gray;

  hca_div #(.NW(NW), .DW(DW), .TW(CB)) u_hue_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .num      (f_hnum),
    .den      (f_hden),
    .in_tag   (f_mx),
    .out_valid(hd_valid),
    .quo      (hd_quo),
    .out_tag  (hd_mx)
  );

  hca_div #(.NW(NW), .DW(DW), .TW(1)) u_sat_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .num      (f_snum),
    .den      (f_sden),
    .in_tag   (f_gray),
    .out_valid(sd_valid),
    .quo      (sd_quo),
    .out_tag  (sd_gray)
  );

  hca_back #(.CB(CB), .HB(HB), .SW(SW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hd_valid && sd_valid),
    .hue       (hd_quo[HB-1:0]),
    .sat       (sd_quo[SW-1:0]),
    .max_ch    (hd_mx),
    .gray      (sd_gray),
    .hue_offset(hue_off_r),
    .sat_offset(sat_off_r),
    .val_offset(val_off_r),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// File: tb/hsv_color_adjust_tb.sv
// ----------------------------------------------------------------------------
// hsv_color_adjust_tb
// Drives RGB pixels through the HSV adjust block under several offset settings
// and checks every output pixel against a fixed-point HSV predictor.
// ----------------------------------------------------------------------------
module hsv_color_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    logic [15:0] hue_shift;
    int sat_shift;
    int val_shift;
    int mismatches;
    int checked;

    function automatic longint unsigned shade(longint unsigned vv, longint unsigned ss,
                                              longint unsigned g);
      longint unsigned a;
      longint unsigned k;
      a = (ss * g + 32768) >> 16;
      k = (a > 65280) ? 0 : 65280 - a;
      return (vv * k + 32768 * 255) / (65536 * 255);
    endfunction

    function automatic pixel_t adjust(pixel_t px);
      longint unsigned r, g, b, mx, mn, c, h, s, hv, sec, f, pv, qv, tv, vc, vv;
      longint n;
      longint snew;
      longint vnew;
      pixel_t res;
      r = px.red; g = px.green; b = px.blue;
      mx = r; mn = r; h = 0; s = 0;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      if (c > 0) begin
        if (r == mx) begin
          n = longint'(g) - longint'(b);
          if (n < 0) n += 6 * longint'(c);
        end else if (g == mx) begin
          n = 2 * longint'(c) + longint'(b) - longint'(r);
        end else begin
          n = 4 * longint'(c) + longint'(r) - longint'(g);
        end
        h = (unsigned'(n) << 16) / (6 * c);
        s = (c * 65280) / mx;
      end
      hv = (h + hue_shift) & 16'hFFFF;
      snew = longint'(s) + sat_shift * 255;
      vnew = longint'(mx * 256) + val_shift * 255;
      if (snew < 0) snew = 0;
      if (snew > 65280) snew = 65280;
      if (vnew < 0) vnew = 0;
      if (vnew > 65280) vnew = 65280;
      s = snew; vv = vnew;
      sec = (hv * 6) >> 16;
      f = (hv * 6) & 16'hFFFF;
      pv = shade(vv, s, 65536);
      qv = shade(vv, s, f);
      tv = shade(vv, s, 65536 - f);
      vc = shade(vv, s, 0);
      case (sec)
        0: res = {vc[7:0], tv[7:0], pv[7:0]};
        1: res = {qv[7:0], vc[7:0], pv[7:0]};
        2: res = {pv[7:0], vc[7:0], tv[7:0]};
        3: res = {pv[7:0], qv[7:0], vc[7:0]};
        4: res = {tv[7:0], pv[7:0], vc[7:0]};
        default: res = {vc[7:0], pv[7:0], qv[7:0]};
      endcase
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      expected_pixels.push_back(adjust(px));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output pixel %h", got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [7:0] in_red = 0, in_green = 0, in_blue = 0;
  logic out_valid;
  logic [7:0] out_red, out_green, out_blue;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [hca_pkg::CFG_INDEX_BITS-1:0] cfg_index = hca_pkg::CFG_HUE_OFFSET;
  logic [hca_pkg::CFG_DATA_BITS-1:0] cfg_data = 0;

  pixel_scoreboard board = new();
  int cycles = 0;
  int sent = 0;
  int settings_done = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  hsv_color_adjust i_dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) board.check_pixel({out_red, out_green, out_blue});
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(hca_pkg::cfg_index_t idx, logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hca_pkg::CFG_HUE_OFFSET: board.hue_shift = data;
      hca_pkg::CFG_SAT_OFFSET: board.sat_shift = $signed(data[9:0]);
      default: board.val_shift = $signed(data[9:0]);
    endcase
  endtask

  task automatic set_offsets(logic [15:0] hue, int sat, int val);
    logic [15:0] sd, vd;
    sd = 16'(sat);
    vd = 16'(val);
    sd[15:10] = 6'($urandom);
    vd[15:10] = 6'($urandom);
    write_reg(hca_pkg::CFG_HUE_OFFSET, hue);
    write_reg(hca_pkg::CFG_SAT_OFFSET, sd);
    write_reg(hca_pkg::CFG_VAL_OFFSET, vd);
    cfg_valid <= 0;
    settings_done++;
  endtask

  task automatic send_pixel(pixel_t px, bit allow_gaps);
    if (allow_gaps) begin
      while ($urandom_range(99) < 32) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 1;
    in_red <= px.red;
    in_green <= px.green;
    in_blue <= px.blue;
    do @(posedge clk); while (busy);
    board.note_pixel(px);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(5))
      0: begin
        px.red = 8'($urandom);
        px.green = px.red;
        px.blue = px.red;
      end
      1: begin
        px = 24'($urandom);
        px.green = px.red;
      end
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  initial begin
    pixel_t directed[$];
    directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
                 24'h010000, 24'h7F3C19, 24'h1980C8, 24'hAA55FF, 24'h0102FE,
                 24'hFEFF00, 24'hFF00FE, 24'h555555, 24'hC80A64, 24'h30FF30};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_pixel(directed[i], 0);
    drain();
    set_offsets(16'hFFFF, 256, -256);
    foreach (directed[i]) send_pixel(directed[i], 1);
    drain();
    set_offsets(16'h8000, -256, 256);
    foreach (directed[i]) send_pixel(directed[i], 1);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      set_offsets(16'($urandom), int'($urandom_range(512)) - 256,
                  int'($urandom_range(512)) - 256);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && phase == 2) drain();
        send_pixel(random_pixel(), phase != 3);
      end
      drain();
    end
    $display("covered %0d pixels across %0d offset settings, %0d outputs checked",
             sent, settings_done + 1, board.checked);
    if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
